@@ hw/rtl/dbr_pkg.sv @@
package dbr_pkg;

    localparam int OUT_W     = 24;
    localparam int HALF_W    = 8;
    localparam int TIMEOUT_W = 32;
    localparam int GAIN_W    = 2;
    localparam int SETTLE_W  = 16;
    localparam int CFG_W     = 32;
    localparam int ADDR_W    = 2;

    // Register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [ADDR_W-1:0] REG_TIMEOUT     = 2'd1;
    localparam logic [ADDR_W-1:0] REG_GAIN        = 2'd2;
    localparam logic [ADDR_W-1:0] REG_SETTLE      = 2'd3;

    localparam logic [HALF_W-1:0]    HALF_RESET    = 8'd1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000000;
    localparam logic [GAIN_W-1:0]    GAIN_RESET    = 2'd0;
    localparam logic [SETTLE_W-1:0]  SETTLE_RESET  = 16'd1000;

    // Operation codes carried by each input word
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DOWN  = 2'd2;
    localparam logic [1:0] OP_UP    = 2'd3;

    // Gain selections
    localparam logic [GAIN_W-1:0] GAIN_128 = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_32  = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_64  = 2'd2;

    typedef struct packed {
        logic [HALF_W-1:0]    half_period_ticks;
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [GAIN_W-1:0]    gain_select;
        logic [SETTLE_W-1:0]  settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value_b;
        logic signed [OUT_W-1:0] value_a;
        logic                    timed_out;
        logic                    done_res;
        logic                    busy_res;
        logic                    clk_out;
    } result_t;

endpackage

@@ hw/rtl/dual_bridge_adc_serial_reader.sv @@
// A result word is registered and valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the input is stalled only while a result
// waits in the output register and the output side is not ready.
// Reset (rst_n low, asynchronous): sequencer idle, clock line low, samples zero,
// configuration registers at their default values, output register empty.
module dual_bridge_adc_serial_reader #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] operation, [2] dout_a, [3] dout_b, [7:4] zero
    input  logic [7:0]             s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] clk_out, [1] busy_res, [2] done_res, [3] timed_out,
    // [27:4] value_a, [51:28] value_b, [55:52] zero
    output logic [55:0]            m_axis_tdata,

    input  logic                   cfg_we,
    input  logic [dbr_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [dbr_pkg::CFG_W-1:0]  cfg_wdata
);

    dbr_pkg::cfg_t    cfg_reg;
    dbr_pkg::result_t res;
    dbr_pkg::result_t out_data_reg;
    logic             out_valid_reg;
    logic             accept;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= dbr_pkg::HALF_RESET;
            cfg_reg.timeout_ticks     <= dbr_pkg::TIMEOUT_RESET;
            cfg_reg.gain_select       <= dbr_pkg::GAIN_RESET;
            cfg_reg.settle_ticks      <= dbr_pkg::SETTLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                dbr_pkg::REG_HALF_PERIOD:
                    cfg_reg.half_period_ticks <= cfg_wdata[dbr_pkg::HALF_W-1:0];
                dbr_pkg::REG_TIMEOUT:
                    cfg_reg.timeout_ticks <= cfg_wdata[dbr_pkg::TIMEOUT_W-1:0];
                dbr_pkg::REG_GAIN:
                    cfg_reg.gain_select <= cfg_wdata[dbr_pkg::GAIN_W-1:0];
                dbr_pkg::REG_SETTLE:
                    cfg_reg.settle_ticks <= cfg_wdata[dbr_pkg::SETTLE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    dbr_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .operation (s_axis_tdata[1:0]),
        .dout_a    (s_axis_tdata[2]),
        .dout_b    (s_axis_tdata[3]),
        .cfg       (cfg_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_data_reg};

endmodule

@@ hw/rtl/dbr_core.sv @@
module dbr_core #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [1:0]      operation,
    input  logic            dout_a,
    input  logic            dout_b,
    input  dbr_pkg::cfg_t   cfg,
    output dbr_pkg::result_t res
);

    localparam int PW = $clog2(SAMPLE_BITS + 4);
    localparam logic [PW-1:0] BITS_P = PW'(SAMPLE_BITS);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_WAIT   = 3'd1;
    localparam logic [2:0] PH_HIGH   = 3'd2;
    localparam logic [2:0] PH_LOW    = 3'd3;
    localparam logic [2:0] PH_SETTLE = 3'd4;
    localparam logic [2:0] PH_DOWN   = 3'd5;

    logic [2:0]                     phase_reg, phase_next;
    logic [dbr_pkg::TIMEOUT_W-1:0]  wait_count_reg, wait_count_next;
    logic [dbr_pkg::HALF_W-1:0]     half_count_reg, half_count_next;
    logic [PW-1:0]                  pulse_index_reg, pulse_index_next;
    logic [SAMPLE_BITS-1:0]         shift_a_reg, shift_a_next;
    logic [SAMPLE_BITS-1:0]         shift_b_reg, shift_b_next;
    logic                           clock_level_reg, clock_level_next;
    logic [dbr_pkg::OUT_W-1:0]      last_a_reg, last_a_next;
    logic [dbr_pkg::OUT_W-1:0]      last_b_reg, last_b_next;
    logic [1:0]                     extra_reg, extra_next;

    logic [dbr_pkg::HALF_W-1:0]     half_eff;
    logic                           half_end;
    logic [PW-1:0]                  pulse_inc;
    logic [dbr_pkg::OUT_W-1:0]      ext_a;
    logic [dbr_pkg::OUT_W-1:0]      ext_b;
    logic                           done;
    logic                           tout;

    // Sign-extend (or wrap) the received sample to the output width.
    generate
        if (SAMPLE_BITS >= dbr_pkg::OUT_W)
        begin : g_cut
            assign ext_a = shift_a_reg[dbr_pkg::OUT_W-1:0];
            assign ext_b = shift_b_reg[dbr_pkg::OUT_W-1:0];
        end
        else
        begin : g_ext
            assign ext_a = {{(dbr_pkg::OUT_W-SAMPLE_BITS){shift_a_reg[SAMPLE_BITS-1]}},
                            shift_a_reg};
            assign ext_b = {{(dbr_pkg::OUT_W-SAMPLE_BITS){shift_b_reg[SAMPLE_BITS-1]}},
                            shift_b_reg};
        end
    endgenerate

    assign half_eff  = (cfg.half_period_ticks == '0) ? dbr_pkg::HALF_W'(1)
                                                     : cfg.half_period_ticks;
    assign half_end  = ({1'b0, half_count_reg} + 9'd1) >= {1'b0, half_eff};
    assign pulse_inc = pulse_index_reg + PW'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        wait_count_next  = wait_count_reg;
        half_count_next  = half_count_reg;
        pulse_index_next = pulse_index_reg;
        shift_a_next     = shift_a_reg;
        shift_b_next     = shift_b_reg;
        clock_level_next = clock_level_reg;
        last_a_next      = last_a_reg;
        last_b_next      = last_b_reg;
        extra_next       = extra_reg;
        done             = 1'b0;
        tout             = 1'b0;

        case (phase_reg)
            PH_IDLE, PH_DOWN:
            begin
                if (operation == dbr_pkg::OP_START && phase_reg == PH_IDLE)
                begin
                    phase_next      = PH_WAIT;
                    wait_count_next = '0;
                end
                else if (operation == dbr_pkg::OP_DOWN)
                begin
                    phase_next       = PH_DOWN;
                    clock_level_next = 1'b1;
                end
                else if (operation == dbr_pkg::OP_UP)
                begin
                    clock_level_next = 1'b0;
                    wait_count_next  = dbr_pkg::TIMEOUT_W'(cfg.settle_ticks);
                    phase_next       = (cfg.settle_ticks != '0) ? PH_SETTLE : PH_IDLE;
                end
            end
            PH_SETTLE:
            begin
                if (wait_count_reg <= dbr_pkg::TIMEOUT_W'(1))
                begin
                    wait_count_next = '0;
                    phase_next      = PH_IDLE;
                end
                else
                begin
                    wait_count_next = wait_count_reg - dbr_pkg::TIMEOUT_W'(1);
                end
            end
            PH_HIGH:
            begin
                if (half_end)
                begin
                    if (pulse_index_reg < BITS_P)
                    begin
                        shift_a_next = {shift_a_reg[SAMPLE_BITS-2:0], dout_a};
                        shift_b_next = {shift_b_reg[SAMPLE_BITS-2:0], dout_b};
                    end
                    clock_level_next = 1'b0;
                    half_count_next  = '0;
                    phase_next       = PH_LOW;
                end
                else
                begin
                    half_count_next = half_count_reg + dbr_pkg::HALF_W'(1);
                end
            end
            PH_LOW:
            begin
                if (half_end)
                begin
                    pulse_index_next = pulse_inc;
                    half_count_next  = '0;
                    if (pulse_inc < BITS_P + PW'(extra_reg))
                    begin
                        clock_level_next = 1'b1;
                        phase_next       = PH_HIGH;
                    end
                    else
                    begin
                        last_a_next = ext_a;
                        last_b_next = ext_b;
                        done        = 1'b1;
                        phase_next  = PH_IDLE;
                    end
                end
                else
                begin
                    half_count_next = half_count_reg + dbr_pkg::HALF_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        // The ready check also runs on the word that starts the wait.
        if (phase_next == PH_WAIT)
        begin
            if (!dout_a && !dout_b)
            begin
                shift_a_next     = '0;
                shift_b_next     = '0;
                pulse_index_next = '0;
                case (cfg.gain_select)
                    dbr_pkg::GAIN_32: extra_next = 2'd2;
                    dbr_pkg::GAIN_64: extra_next = 2'd3;
                    default:          extra_next = 2'd1;
                endcase
                clock_level_next = 1'b1;
                half_count_next  = '0;
                phase_next       = PH_HIGH;
            end
            else if (wait_count_next > cfg.timeout_ticks)
            begin
                tout       = 1'b1;
                phase_next = PH_IDLE;
            end
            else if (wait_count_next != '1)
            begin
                wait_count_next = wait_count_next + dbr_pkg::TIMEOUT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            wait_count_reg  <= '0;
            half_count_reg  <= '0;
            pulse_index_reg <= '0;
            shift_a_reg     <= '0;
            shift_b_reg     <= '0;
            clock_level_reg <= 1'b0;
            last_a_reg      <= '0;
            last_b_reg      <= '0;
            extra_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            wait_count_reg  <= wait_count_next;
            half_count_reg  <= half_count_next;
            pulse_index_reg <= pulse_index_next;
            shift_a_reg     <= shift_a_next;
            shift_b_reg     <= shift_b_next;
            clock_level_reg <= clock_level_next;
            last_a_reg      <= last_a_next;
            last_b_reg      <= last_b_next;
            extra_reg       <= extra_next;
        end
    end

    assign res.clk_out   = clock_level_next;
    assign res.busy_res  = (phase_next == PH_WAIT) || (phase_next == PH_HIGH) ||
                           (phase_next == PH_LOW)  || (phase_next == PH_SETTLE);
    assign res.done_res  = done;
    assign res.timed_out = tout;
    assign res.value_a   = last_a_next;
    assign res.value_b   = last_b_next;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import dbr_pkg::*;

    localparam int SAMPLE_BITS = 24;
    localparam int CYCLE_LIMIT = 100000;
    localparam int MAX_REPORTS = 100;
    localparam int ITEM_TARGET = 950;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_WAIT,
        SEQ_HIGH,
        SEQ_LOW,
        SEQ_SETTLE,
        SEQ_DOWN
    } seq_phase_e;

    class reader_scoreboard;
        logic [HALF_W-1:0]      half_period;
        logic [TIMEOUT_W-1:0]   timeout_limit;
        logic [GAIN_W-1:0]      gain_sel;
        logic [SETTLE_W-1:0]    settle_len;

        seq_phase_e             phase;
        logic [31:0]            wait_count;
        logic [HALF_W-1:0]      half_count;
        int unsigned            pulse_index;
        int unsigned            extra_pulses;
        logic [SAMPLE_BITS-1:0] shift_a;
        logic [SAMPLE_BITS-1:0] shift_b;
        logic                   clock_level;
        logic [OUT_W-1:0]       last_a;
        logic [OUT_W-1:0]       last_b;

        result_t                predicted_outputs[$];
        int                     errors;
        int                     ticks_noted;

        function new();
            half_period   = HALF_RESET;
            timeout_limit = TIMEOUT_RESET;
            gain_sel      = GAIN_RESET;
            settle_len    = SETTLE_RESET;
            phase         = SEQ_IDLE;
            wait_count    = '0;
            half_count    = '0;
            pulse_index   = 0;
            extra_pulses  = 0;
            shift_a       = '0;
            shift_b       = '0;
            clock_level   = 1'b0;
            last_a        = '0;
            last_b        = '0;
            errors        = 0;
            ticks_noted   = 0;
        endfunction

        function void set_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_HALF_PERIOD: half_period   = val[HALF_W-1:0];
                REG_TIMEOUT:     timeout_limit = val[TIMEOUT_W-1:0];
                REG_GAIN:        gain_sel      = val[GAIN_W-1:0];
                REG_SETTLE:      settle_len    = val[SETTLE_W-1:0];
                default:         ;
            endcase
        endfunction

        function logic [OUT_W-1:0] to_output(logic [SAMPLE_BITS-1:0] raw);
            logic [63:0] wide;
            wide = {{(64-SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw};
            return wide[OUT_W-1:0];
        endfunction

        function void start_pulse();
            clock_level = 1'b1;
            half_count  = '0;
            phase       = SEQ_HIGH;
        endfunction

        // Advances the predicted sequencer by one tick and queues the word it should emit.
        function void note_tick(logic [1:0] op, logic da, logic db);
            logic [8:0] half;
            logic       done;
            logic       tout;
            result_t    want;
            half = (half_period == '0) ? 9'd1 : {1'b0, half_period};
            done = 1'b0;
            tout = 1'b0;
            ticks_noted++;
            case (phase)
                SEQ_IDLE, SEQ_DOWN:
                begin
                    if (op == OP_START && phase == SEQ_IDLE)
                    begin
                        phase      = SEQ_WAIT;
                        wait_count = '0;
                    end
                    else if (op == OP_DOWN)
                    begin
                        phase       = SEQ_DOWN;
                        clock_level = 1'b1;
                    end
                    else if (op == OP_UP)
                    begin
                        clock_level = 1'b0;
                        wait_count  = {16'd0, settle_len};
                        phase       = (settle_len != '0) ? SEQ_SETTLE : SEQ_IDLE;
                    end
                end
                SEQ_SETTLE:
                begin
                    if (wait_count != '0)
                        wait_count--;
                    if (wait_count == '0)
                        phase = SEQ_IDLE;
                end
                SEQ_HIGH:
                begin
                    if ({1'b0, half_count} + 9'd1 >= half)
                    begin
                        if (pulse_index < SAMPLE_BITS)
                        begin
                            shift_a = {shift_a[SAMPLE_BITS-2:0], da};
                            shift_b = {shift_b[SAMPLE_BITS-2:0], db};
                        end
                        clock_level = 1'b0;
                        half_count  = '0;
                        phase       = SEQ_LOW;
                    end
                    else
                        half_count++;
                end
                SEQ_LOW:
                begin
                    if ({1'b0, half_count} + 9'd1 >= half)
                    begin
                        pulse_index++;
                        if (pulse_index < SAMPLE_BITS + extra_pulses)
                            start_pulse();
                        else
                        begin
                            last_a     = to_output(shift_a);
                            last_b     = to_output(shift_b);
                            done       = 1'b1;
                            half_count = '0;
                            phase      = SEQ_IDLE;
                        end
                    end
                    else
                        half_count++;
                end
                default: ;
            endcase

            // The ready check also runs on the tick that issued the start.
            if (phase == SEQ_WAIT)
            begin
                if (!da && !db)
                begin
                    shift_a      = '0;
                    shift_b      = '0;
                    pulse_index  = 0;
                    extra_pulses = (gain_sel == GAIN_32) ? 2 : (gain_sel == GAIN_64) ? 3 : 1;
                    start_pulse();
                end
                else if (wait_count > timeout_limit)
                begin
                    tout  = 1'b1;
                    phase = SEQ_IDLE;
                end
                else if (wait_count != '1)
                    wait_count++;
            end

            want.clk_out   = clock_level;
            want.busy_res  = (phase == SEQ_WAIT || phase == SEQ_HIGH ||
                              phase == SEQ_LOW || phase == SEQ_SETTLE);
            want.done_res  = done;
            want.timed_out = tout;
            want.value_a   = last_a;
            want.value_b   = last_b;
            predicted_outputs.push_back(want);
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_REPORTS)
                $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [51:0] word);
            result_t got;
            result_t want;
            got = word;
            if (predicted_outputs.size() == 0)
                report_mismatch($sformatf("output word %h arrived with nothing expected", word));
            else
            begin
                want = predicted_outputs.pop_front();
                if (got.clk_out !== want.clk_out)
                    report_mismatch($sformatf("clk_out %b, expected %b",
                                              got.clk_out, want.clk_out));
                if (got.busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res %b, expected %b",
                                              got.busy_res, want.busy_res));
                if (got.done_res !== want.done_res)
                    report_mismatch($sformatf("done_res %b, expected %b",
                                              got.done_res, want.done_res));
                if (got.timed_out !== want.timed_out)
                    report_mismatch($sformatf("timed_out %b, expected %b",
                                              got.timed_out, want.timed_out));
                if (got.value_a !== want.value_a)
                    report_mismatch($sformatf("value_a %h, expected %h",
                                              got.value_a, want.value_a));
                if (got.value_b !== want.value_b)
                    report_mismatch($sformatf("value_b %h, expected %h",
                                              got.value_b, want.value_b));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // [1:0] operation, [2] dout_a, [3] dout_b, [7:4] zero
    logic [7:0]          s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [0] clk_out, [1] busy_res, [2] done_res, [3] timed_out,
    // [27:4] value_a, [51:28] value_b, [55:52] zero
    logic [55:0]         m_axis_tdata;
    logic                cfg_we;
    logic [ADDR_W-1:0]   cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;

    reader_scoreboard    sb;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  cycle_count;

    dual_bridge_adc_serial_reader #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("dual_bridge_adc_serial_reader test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_tick(s_axis_tdata[1:0], s_axis_tdata[2], s_axis_tdata[3]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[51:0]);
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic set_idling(int unsigned sel);
        case (sel)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken,
    // with tvalid still high so that back-to-back words need no extra step.
    // The idling phase follows the share of words already sent.
    task automatic send_word(input logic [1:0] op, input logic da, input logic db);
        set_idling((sb.ticks_noted * 4) / ITEM_TARGET);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, db, da, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic hold_input_until_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.predicted_outputs.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        hold_input_until_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    function automatic logic [1:0] not_ready_lines();
        logic [1:0] v;
        v = 2'($urandom_range(1, 3));
        return v;
    endfunction

    // Plain ticks with both lines ready until the sequencer is idle or powered down.
    task automatic run_to_rest();
        while (sb.phase != SEQ_IDLE && sb.phase != SEQ_DOWN)
            send_word(OP_TICK, 1'b0, 1'b0);
    endtask

    // Start request, data lines held not ready for not_ready ticks, then the
    // sample patterns presented MSB first, one bit per clock pulse.
    task automatic take_reading(input logic [SAMPLE_BITS-1:0] pat_a,
                                input logic [SAMPLE_BITS-1:0] pat_b,
                                input int unsigned not_ready);
        logic [1:0]  lines;
        int unsigned waited;
        int unsigned bit_pos;
        logic        da;
        logic        db;
        lines = (not_ready > 0) ? not_ready_lines() : 2'b00;
        send_word(OP_START, lines[0], lines[1]);
        waited = 1;
        while (sb.phase == SEQ_WAIT)
        begin
            lines = (waited < not_ready) ? not_ready_lines() : 2'b00;
            send_word(2'($urandom_range(0, 3)), lines[0], lines[1]);
            waited++;
        end
        while (sb.phase == SEQ_HIGH || sb.phase == SEQ_LOW)
        begin
            if (sb.pulse_index < SAMPLE_BITS)
            begin
                bit_pos = SAMPLE_BITS - 1 - sb.pulse_index;
                da = pat_a[bit_pos];
                db = pat_b[bit_pos];
            end
            else
            begin
                da = 1'($urandom_range(0, 1));
                db = 1'($urandom_range(0, 1));
            end
            send_word(2'($urandom_range(0, 3)), da, db);
        end
    endtask

    task automatic power_cycle(input int unsigned ticks_down);
        send_word(OP_DOWN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        // Starts and repeated power-downs are ignored here, the clock stays high.
        repeat (ticks_down)
            send_word(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        send_word(OP_UP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        run_to_rest();
    endtask

    task automatic noise_burst(input int unsigned count);
        repeat (count)
            send_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        if (sb.phase == SEQ_DOWN)
            send_word(OP_UP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        run_to_rest();
    endtask

    task automatic random_config();
        logic [HALF_W-1:0]    h;
        logic [TIMEOUT_W-1:0] t;
        logic [SETTLE_W-1:0]  s;
        int unsigned          r;
        r = $urandom_range(0, 9);
        h = (r < 5) ? 8'd1 : (r < 7) ? 8'd2 : (r < 8) ? 8'd0 : 8'($urandom_range(3, 4));
        r = $urandom_range(0, 9);
        t = (r < 4) ? 32'($urandom_range(5, 20)) : (r < 5) ? 32'd0 : (r < 6) ? '1 : $urandom;
        s = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 40));
        write_reg(REG_HALF_PERIOD, {24'd0, h});
        write_reg(REG_TIMEOUT, t);
        write_reg(REG_GAIN, 32'($urandom_range(0, 3)));
        write_reg(REG_SETTLE, {16'd0, s});
    endtask

    initial
    begin
        int unsigned round_idx;
        int unsigned pick;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        cycle_count   = 0;
        sb            = new();
        set_idling(0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults in force for one reading, then a short settling time.
        send_word(OP_TICK, 1'b1, 1'b1);
        take_reading(24'h800000, 24'h7FFFFF, 3);
        write_reg(REG_SETTLE, 32'd20);
        send_word(OP_UP, 1'b0, 1'b0);
        run_to_rest();

        // A zero half period behaves as one.
        write_reg(REG_HALF_PERIOD, 32'd0);
        write_reg(REG_GAIN, {30'd0, GAIN_32});
        take_reading('1, '0, 0);
        write_reg(REG_HALF_PERIOD, 32'd2);
        write_reg(REG_GAIN, {30'd0, GAIN_64});
        take_reading(24'h5A3C96, 24'h800000, 1);
        write_reg(REG_HALF_PERIOD, 32'd1);
        write_reg(REG_GAIN, 32'd3);
        take_reading(24'h7FFFFF, 24'hFFFFFF, 0);

        // Zero timeout gives up on the second waiting tick unless ready at once.
        write_reg(REG_TIMEOUT, 32'd0);
        take_reading(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 100);
        take_reading(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 0);
        write_reg(REG_TIMEOUT, 32'd1);
        take_reading(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 100);
        write_reg(REG_TIMEOUT, 32'hFFFFFFFF);
        take_reading(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 12);

        // Power down ignores starts; power up with no settling is idle at once.
        write_reg(REG_SETTLE, 32'd0);
        send_word(OP_DOWN, 1'b1, 1'b0);
        send_word(OP_START, 1'b0, 1'b0);
        send_word(OP_TICK, 1'b0, 1'b1);
        send_word(OP_DOWN, 1'b1, 1'b1);
        send_word(OP_UP, 1'b0, 1'b0);
        write_reg(REG_SETTLE, 32'd30);
        send_word(OP_UP, 1'b1, 1'b1);
        run_to_rest();
        write_reg(REG_HALF_PERIOD, 32'd3);
        take_reading(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 0);

        round_idx = 0;
        while (sb.ticks_noted < ITEM_TARGET)
        begin
            run_to_rest();
            if (round_idx % 3 == 0)
                random_config();
            pick = $urandom_range(0, 99);
            if (pick < 60)
                take_reading(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                             $urandom_range(0, 6));
            else if (pick < 70)
                take_reading(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 40);
            else if (pick < 80)
                power_cycle($urandom_range(0, 4));
            else
                noise_burst($urandom_range(1, 8));
            if ($urandom_range(0, 19) == 0)
                hold_input_until_drained();
            round_idx++;
        end

        run_to_rest();
        hold_input_until_drained();
        repeat (8) @(posedge clk);
        if (sb.predicted_outputs.size() != 0)
            sb.report_mismatch("results still expected at the end of the run");
        if (sb.errors == 0)
            $display("dual_bridge_adc_serial_reader test passed");
        else
            $display("dual_bridge_adc_serial_reader test failed");
        $finish;
    end

endmodule
